>>> rtl/iis_pkg.sv
package iis_pkg;

	localparam int CFG_W   = 12;
	localparam int IDX_W   = 2;
	localparam int PIXEL_W = 8;
	localparam int SUM_W   = 30;
	localparam int SQ_W    = 38;
	localparam int POS_W   = 11;

	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [IDX_W-1:0] REG_SQUARED_ENABLE = 2'd2;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
	localparam logic             SQ_EN_RESET  = 1'b1;

	typedef struct packed {
		logic first_col;
		logic first_row;
		logic last_of_frame;
	} pos_flags_t;

endpackage

>>> rtl/iis_position.sv
module iis_position #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             advance,
	input  logic [iis_pkg::CFG_W-1:0]        image_width,
	input  logic [iis_pkg::CFG_W-1:0]        image_height,
	output logic [$clog2(MAX_WIDTH)-1:0]     col,
	output logic [$clog2(MAX_HEIGHT)-1:0]    row,
	output iis_pkg::pos_flags_t              flags
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WX = ((CW > iis_pkg::CFG_W) ? CW : iis_pkg::CFG_W) + 1;
	localparam int HX = ((RW > iis_pkg::CFG_W) ? RW : iis_pkg::CFG_W) + 1;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [WX-1:0] w_cfg;
	logic [WX-1:0] w_lim;
	logic [HX-1:0] h_cfg;
	logic [HX-1:0] h_lim;
	logic          end_row;
	logic          end_frame;

	assign w_cfg = WX'(image_width);
	assign h_cfg = HX'(image_height);

	// A zero dimension counts as one; a dimension beyond MAX_WIDTH or MAX_HEIGHT saturates to that bound.
	always_comb begin
		if (w_cfg == '0) begin
			w_lim = WX'(1);
		end else if (w_cfg > WX'(MAX_WIDTH)) begin
			w_lim = WX'(MAX_WIDTH);
		end else begin
			w_lim = w_cfg;
		end
		if (h_cfg == '0) begin
			h_lim = HX'(1);
		end else if (h_cfg > HX'(MAX_HEIGHT)) begin
			h_lim = HX'(MAX_HEIGHT);
		end else begin
			h_lim = h_cfg;
		end
	end

	assign end_row   = (WX'(col_q) + WX'(1)) >= w_lim;
	assign end_frame = end_row && ((HX'(row_q) + HX'(1)) >= h_lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (end_row) begin
				col_q <= '0;
				row_q <= end_frame ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	assign col                 = col_q;
	assign row                 = row_q;
	assign flags.first_col     = (col_q == '0);
	assign flags.first_row     = (row_q == '0);
	assign flags.last_of_frame = end_frame;

endmodule

>>> rtl/iis_line_store.sv
module iis_line_store #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11,
	parameter int DW    = 68
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_q;
	logic [DW-1:0] fwd_data_q;
	logic          fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// A read that meets a write to the same entry in one cycle takes the new data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

endmodule

>>> rtl/iis_datapath.sv
module iis_datapath #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	output logic                                       accept,
	input  logic [iis_pkg::PIXEL_W-1:0]                pixel,
	input  logic [$clog2(MAX_WIDTH)-1:0]               col_in,
	input  logic [$clog2(MAX_HEIGHT)-1:0]              row_in,
	input  iis_pkg::pos_flags_t                        flags,
	input  logic                                       squared_enable,
	input  logic [iis_pkg::SUM_W+iis_pkg::SQ_W-1:0]    ls_rd_data,
	output logic                                       ls_wr_en,
	output logic [$clog2(MAX_WIDTH)-1:0]               ls_wr_addr,
	output logic [iis_pkg::SUM_W+iis_pkg::SQ_W-1:0]    ls_wr_data,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic [iis_pkg::SUM_W-1:0]                  sum_value,
	output logic [iis_pkg::SQ_W-1:0]                   sq_sum_value,
	output logic [iis_pkg::POS_W-1:0]                  col,
	output logic [iis_pkg::POS_W-1:0]                  row,
	output logic                                       last_of_frame
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int RW     = $clog2(MAX_HEIGHT);
	localparam int PX_W   = (PIXEL_BITS < iis_pkg::PIXEL_W) ? PIXEL_BITS : iis_pkg::PIXEL_W;
	localparam int RUN_W  = (CW + PX_W < iis_pkg::SUM_W) ? CW + PX_W : iis_pkg::SUM_W;
	localparam int RSQ_W  = (CW + 2 * PX_W < iis_pkg::SQ_W) ? CW + 2 * PX_W : iis_pkg::SQ_W;

	logic [PX_W-1:0]           px;
	logic [2*PX_W-1:0]         px_sq;
	logic [RUN_W-1:0]          run_q;
	logic [RSQ_W-1:0]          rsq_q;
	logic [RUN_W-1:0]          run_next;
	logic [RSQ_W-1:0]          rsq_next;

	logic                      valid_s1;
	logic [RUN_W-1:0]          run_s1;
	logic [RSQ_W-1:0]          rsq_s1;
	logic [CW-1:0]             col_s1;
	logic [RW-1:0]             row_s1;
	logic                      last_s1;
	logic                      first_row_s1;
	logic                      adv_s1;

	logic [iis_pkg::SUM_W-1:0] above_sum;
	logic [iis_pkg::SQ_W-1:0]  above_sq;
	logic [iis_pkg::SUM_W-1:0] sum_s1;
	logic [iis_pkg::SQ_W-1:0]  sq_s1;

	logic                      valid_s2;
	logic [iis_pkg::SUM_W-1:0] sum_s2;
	logic [iis_pkg::SQ_W-1:0]  sq_s2;
	logic [CW-1:0]             col_s2;
	logic [RW-1:0]             row_s2;
	logic                      last_s2;

	assign adv_s1   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s1;
	assign accept   = in_valid && in_ready;

	assign px       = pixel[PX_W-1:0];
	assign px_sq    = px * px;
	assign run_next = (flags.first_col ? '0 : run_q) + RUN_W'(px);
	assign rsq_next = (flags.first_col ? '0 : rsq_q) + RSQ_W'(px_sq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= '0;
			rsq_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				run_q    <= run_next;
				rsq_q    <= rsq_next;
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			run_s1       <= run_next;
			rsq_s1       <= rsq_next;
			col_s1       <= col_in;
			row_s1       <= row_in;
			last_s1      <= flags.last_of_frame;
			first_row_s1 <= flags.first_row;
		end
	end

	// The first row of a frame has nothing above it.
	assign above_sum = first_row_s1 ? '0 : ls_rd_data[iis_pkg::SUM_W-1:0];
	assign above_sq  = first_row_s1 ? '0 : ls_rd_data[iis_pkg::SUM_W+iis_pkg::SQ_W-1:iis_pkg::SUM_W];
	assign sum_s1    = above_sum + iis_pkg::SUM_W'(run_s1);
	assign sq_s1     = above_sq + iis_pkg::SQ_W'(rsq_s1);

	assign ls_wr_en   = valid_s1 && adv_s1;
	assign ls_wr_addr = col_s1;
	assign ls_wr_data = {sq_s1, sum_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ls_wr_en) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ls_wr_en) begin
			sum_s2  <= sum_s1;
			sq_s2   <= squared_enable ? sq_s1 : '0;
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			last_s2 <= last_s1;
		end
	end

	assign out_valid     = valid_s2;
	assign sum_value     = sum_s2;
	assign sq_sum_value  = sq_s2;
	assign col           = iis_pkg::POS_W'(col_s2);
	assign row           = iis_pkg::POS_W'(row_s2);
	assign last_of_frame = last_s2;

endmodule

>>> rtl/integral_image_stream_unit.sv
// Streaming integral image: one summed-area and one squared-sum result per pixel.
// An accepted pixel passes through the stage-one registers, then the output register.
// One pixel per cycle unless out_ready stalls: the line store reads and writes each cycle.
// Asynchronous active-low reset clears the position counters, row sums and handshake
// state and restores the geometry registers to 640 by 480 with the squared path on.
module integral_image_stream_unit #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	parameter int PIXEL_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [iis_pkg::IDX_W-1:0]     cfg_addr,
	input  logic [iis_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [iis_pkg::PIXEL_W-1:0]   pixel,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [iis_pkg::SUM_W-1:0]     sum_value,
	output logic [iis_pkg::SQ_W-1:0]      sq_sum_value,
	output logic [iis_pkg::POS_W-1:0]     col,
	output logic [iis_pkg::POS_W-1:0]     row,
	output logic                          last_of_frame
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int DW = iis_pkg::SUM_W + iis_pkg::SQ_W;

	logic [iis_pkg::CFG_W-1:0] image_width_q;
	logic [iis_pkg::CFG_W-1:0] image_height_q;
	logic                      squared_enable_q;

	logic                      accept;
	logic [CW-1:0]             pos_col;
	logic [RW-1:0]             pos_row;
	iis_pkg::pos_flags_t       pos_flags;
	logic [DW-1:0]             ls_rd_data;
	logic                      ls_wr_en;
	logic [CW-1:0]             ls_wr_addr;
	logic [DW-1:0]             ls_wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q    <= iis_pkg::WIDTH_RESET;
			image_height_q   <= iis_pkg::HEIGHT_RESET;
			squared_enable_q <= iis_pkg::SQ_EN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				iis_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_wdata;
				end
				iis_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_wdata;
				end
				iis_pkg::REG_SQUARED_ENABLE: begin
					squared_enable_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	iis_position #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_position (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.col          (pos_col),
		.row          (pos_row),
		.flags        (pos_flags)
	);

	iis_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW),
		.DW    (DW)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (pos_col),
		.wr_en   (ls_wr_en),
		.wr_addr (ls_wr_addr),
		.wr_data (ls_wr_data),
		.rd_data (ls_rd_data)
	);

	iis_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PIXEL_BITS (PIXEL_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.accept         (accept),
		.pixel          (pixel),
		.col_in         (pos_col),
		.row_in         (pos_row),
		.flags          (pos_flags),
		.squared_enable (squared_enable_q),
		.ls_rd_data     (ls_rd_data),
		.ls_wr_en       (ls_wr_en),
		.ls_wr_addr     (ls_wr_addr),
		.ls_wr_data     (ls_wr_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sum_value      (sum_value),
		.sq_sum_value   (sq_sum_value),
		.col            (col),
		.row            (row),
		.last_of_frame  (last_of_frame)
	);

endmodule

>>> bench/integral_image_stream_unit_test.sv
`timescale 1ns / 100ps

module integral_image_stream_unit_test;
	import iis_pkg::*;

	localparam int MAX_DIM = 2048;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PIXELS = 400;

	typedef enum logic [1:0] {SEND30_RECV75, SEND75_RECV30, NO_GAPS} gap_mode_e;

	typedef struct {
		logic [SUM_W-1:0] sum;
		logic [SQ_W-1:0]  sq;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic             last;
	} pixel_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [IDX_W-1:0]   cfg_addr = '0;
	logic [CFG_W-1:0]   cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [PIXEL_W-1:0] pixel = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [SUM_W-1:0]   sum_value;
	logic [SQ_W-1:0]    sq_sum_value;
	logic [POS_W-1:0]   col;
	logic [POS_W-1:0]   row;
	logic               last_of_frame;

	integral_image_stream_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sum_value(sum_value),
		.sq_sum_value(sq_sum_value),
		.col(col),
		.row(row),
		.last_of_frame(last_of_frame)
	);

	logic [PIXEL_W-1:0] pending_pixels[$];
	pixel_result_t      expected_sums[$];
	pixel_result_t      want;
	gap_mode_e          gap_mode = SEND30_RECV75;

	logic [CFG_W-1:0]   cfg_width = WIDTH_RESET;
	logic [CFG_W-1:0]   cfg_height = HEIGHT_RESET;
	logic               cfg_sq_en = SQ_EN_RESET;
	logic [18:0]        run_sum = '0;
	logic [26:0]        run_sq = '0;
	logic [30:0]        above_sum[MAX_DIM];
	logic [37:0]        above_sq[MAX_DIM];
	logic [POS_W-1:0]   pos_col = '0;
	logic [POS_W-1:0]   pos_row = '0;
	logic [CFG_W-1:0]   store_filled = '0;

	int errors = 0;
	int pixels_sent = 0;
	int frames_seen = 0;
	int phases = 0;
	int stall_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
		if (v == 0)
			return CFG_W'(1);
		if (v > MAX_DIM)
			return CFG_W'(MAX_DIM);
		return v;
	endfunction

	function automatic logic [CFG_W-1:0] pick_dim();
		case ($urandom_range(0, 19))
			0: return CFG_W'(0);
			1: return CFG_W'(1);
			2: return CFG_W'(MAX_DIM);
			3: return CFG_W'($urandom_range(MAX_DIM + 1, 4095));
			4: return CFG_W'($urandom_range(0, 4095));
			5, 6: return CFG_W'($urandom_range(13, 80));
			default: return CFG_W'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic logic [PIXEL_W-1:0] pick_pixel();
		case ($urandom_range(0, 9))
			0: return PIXEL_W'(0);
			1: return PIXEL_W'(255);
			default: return PIXEL_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic integrate_pixel(input logic [PIXEL_W-1:0] px);
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		logic [15:0]      px_sq;
		logic [30:0]      s;
		logic [37:0]      ss;
		logic             end_row;
		logic             end_frame;
		pixel_result_t    r;
		w = eff_dim(cfg_width);
		h = eff_dim(cfg_height);
		px_sq = px * px;
		if (pos_col == 0) begin
			run_sum = '0;
			run_sq = '0;
		end
		run_sum = run_sum + px;
		run_sq = run_sq + px_sq;
		s = 31'(run_sum);
		ss = 38'(run_sq);
		if (pos_row != 0) begin
			s = s + above_sum[pos_col];
			ss = ss + above_sq[pos_col];
		end
		above_sum[pos_col] = s;
		above_sq[pos_col] = ss;
		if ({1'b0, pos_col} >= store_filled)
			store_filled = {1'b0, pos_col} + 12'd1;
		end_row = ({1'b0, pos_col} + 12'd1 >= w);
		end_frame = end_row && ({1'b0, pos_row} + 12'd1 >= h);
		r.sum = s[SUM_W-1:0];
		r.sq = cfg_sq_en ? ss : '0;
		r.col = pos_col;
		r.row = pos_row;
		r.last = end_frame;
		expected_sums.push_back(r);
		if (end_row) begin
			pos_col = '0;
			pos_row = end_frame ? '0 : pos_row + 1'b1;
		end else begin
			pos_col = pos_col + 1'b1;
		end
	endtask

	task automatic flag_mismatch(input string msg);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_IMAGE_WIDTH: cfg_width = val;
			REG_IMAGE_HEIGHT: cfg_height = val;
			REG_SQUARED_ENABLE: cfg_sq_en = val[0];
			default: ;
		endcase
	endtask

	// A wider row below the first may only read line store entries already written.
	task automatic reconfigure(input bit do_w, input bit do_h, input bit do_sq,
			input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val, input logic sq_val);
		logic [CFG_W-1:0] w_fix;
		w_fix = w_val;
		if (do_w && pos_row != 0 && eff_dim(w_val) > store_filled)
			w_fix = store_filled;
		if (do_w)
			write_register(REG_IMAGE_WIDTH, w_fix);
		if (do_h)
			write_register(REG_IMAGE_HEIGHT, h_val);
		if (do_sq)
			write_register(REG_SQUARED_ENABLE, {{(CFG_W-1){1'b0}}, sq_val});
		if (do_w || do_h || do_sq) begin
			@(posedge clk);
			cfg_we <= 1'b0;
		end
		phases++;
	endtask

	// Sampled away from the rising edge so the driver and monitor updates have settled.
	task automatic drain();
		while (pending_pixels.size() != 0 || in_valid || expected_sums.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				integrate_pixel(pixel);
				pixels_sent++;
			end
			if (!in_valid || in_ready) begin
				if (pending_pixels.size() != 0 && $urandom_range(0, 99) >=
						(gap_mode == SEND30_RECV75 ? 30 : gap_mode == SEND75_RECV30 ? 75 : 0)) begin
					in_valid <= 1'b1;
					pixel <= pending_pixels.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(0, 99) >=
				(gap_mode == SEND30_RECV75 ? 75 : gap_mode == SEND75_RECV30 ? 30 : 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_sums.size() == 0) begin
				flag_mismatch($sformatf("result with none pending at col %0d row %0d", col, row));
			end else begin
				want = expected_sums.pop_front();
				if (sum_value !== want.sum)
					flag_mismatch($sformatf("sum_value %0d, expected %0d at col %0d row %0d",
						sum_value, want.sum, want.col, want.row));
				if (sq_sum_value !== want.sq)
					flag_mismatch($sformatf("sq_sum_value %0d, expected %0d at col %0d row %0d",
						sq_sum_value, want.sq, want.col, want.row));
				if (col !== want.col)
					flag_mismatch($sformatf("col %0d, expected %0d", col, want.col));
				if (row !== want.row)
					flag_mismatch($sformatf("row %0d, expected %0d", row, want.row));
				if (last_of_frame !== want.last)
					flag_mismatch($sformatf("last_of_frame %0b, expected %0b at col %0d row %0d",
						last_of_frame, want.last, want.col, want.row));
				if (want.last)
					frames_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int n;
		int random_sent;
		random_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending_pixels.push_back(8'd255);
		pending_pixels.push_back(8'd0);
		pending_pixels.push_back(8'd255);
		drain();

		// Zero geometry means single-pixel frames; the row in progress ends at once.
		reconfigure(1, 1, 1, 12'd0, 12'd0, 1'b0);
		pending_pixels.push_back(8'd255);
		pending_pixels.push_back(8'd170);
		drain();

		// Oversized geometry saturates to the widest frame, so a short run stays in one row.
		reconfigure(1, 1, 1, 12'd4095, 12'd0, 1'b1);
		repeat (40) pending_pixels.push_back(pick_pixel());
		drain();

		reconfigure(1, 1, 0, 12'd3, 12'd2, 1'b0);
		repeat (7) pending_pixels.push_back(8'd255);
		drain();

		reconfigure(0, 0, 1, 12'd0, 12'd0, 1'b0);
		repeat (2) pending_pixels.push_back(8'd255);
		drain();

		reconfigure(0, 0, 1, 12'd0, 12'd0, 1'b1);
		pending_pixels.push_back(8'd0);
		pending_pixels.push_back(8'd255);
		drain();

		reconfigure(1, 1, 0, 12'd2, 12'd4095, 1'b0);
		pending_pixels.push_back(8'd1);
		pending_pixels.push_back(8'd128);
		pending_pixels.push_back(8'd64);
		drain();

		while (random_sent < RANDOM_PIXELS) begin
			if (random_sent < RANDOM_PIXELS / 3)
				gap_mode = SEND30_RECV75;
			else if (random_sent < 2 * RANDOM_PIXELS / 3)
				gap_mode = SEND75_RECV30;
			else
				gap_mode = NO_GAPS;
			reconfigure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), pick_dim(), pick_dim(), 1'($urandom_range(0, 1)));
			n = $urandom_range(5, 40);
			repeat (n) pending_pixels.push_back(pick_pixel());
			random_sent += n;
			drain();
		end

		$display("Run covered %0d pixels in %0d configuration phases, %0d frame ends checked,",
			pixels_sent, phases, frames_seen);
		$display("with geometry from single pixels up to saturated width and squared sums on and off.");
		if (errors == 0 && expected_sums.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/iis_pkg.sv
rtl/iis_position.sv
rtl/iis_line_store.sv
rtl/iis_datapath.sv
rtl/integral_image_stream_unit.sv
bench/integral_image_stream_unit_test.sv
